>>> rtl/utf8_validate_and_repair_core_defines.svh
// Assertion macros used by the UTF-8 validate-and-repair checker.
`ifndef UTF8_VALIDATE_AND_REPAIR_CORE_DEFINES_SVH
`define UTF8_VALIDATE_AND_REPAIR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8VR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8vr check failed");

// Next-cycle implication, disabled while reset is asserted.
`define U8VR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8vr check failed");

`endif

>>> rtl/u8vr_pkg.sv
// Types, constants and byte classification for the UTF-8 validate-and-repair block.
package u8vr_pkg;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_UNEXP_CONT = 3'd1,
    ERR_BAD_CONT   = 3'd2,
    ERR_TRUNC      = 3'd3,
    ERR_OVERLONG   = 3'd4,
    ERR_SURROGATE  = 3'd5,
    ERR_RANGE      = 3'd6,
    ERR_BAD_LEAD   = 3'd7
  } err_kind_e;

  // Replacement character U+FFFD
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  localparam int unsigned MAX_WORDS = 6;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  typedef struct packed {
    err_kind_e  kind;   // error of a lead, ERR_NONE otherwise
    logic [2:0] len;    // sequence length opened, 0 for ASCII or error
  } lead_class_t;

  // One accepted byte's worth of results
  typedef struct packed {
    logic [MAX_WORDS-1:0][7:0] bytes;
    logic [2:0]                nbytes;
    logic                      eos;
    logic                      str_valid;
    err_kind_e                 kind;
    logic [15:0]               offset;
    logic [15:0]               repl;
  } pkt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic lead_class_t lead_class(input logic [7:0] b);
    lead_class_t lc;
    lc.kind = ERR_NONE;
    lc.len  = 3'd0;
    priority if (b <= 8'h7F) begin
      lc.len = 3'd0;
    end else if (b[7:6] == 2'b10) begin
      lc.kind = ERR_UNEXP_CONT;
    end else if (b == 8'hC0 || b == 8'hC1) begin
      lc.kind = ERR_OVERLONG;
    end else if (b >= 8'hF5 && b <= 8'hF7) begin
      lc.kind = ERR_RANGE;
    end else if (b >= 8'hF8) begin
      lc.kind = ERR_BAD_LEAD;
    end else if (b <= 8'hDF) begin
      lc.len = 3'd2;
    end else if (b <= 8'hEF) begin
      lc.len = 3'd3;
    end else begin
      lc.len = 3'd4;
    end
    return lc;
  endfunction

  // Whole-sequence check on lead and second byte
  function automatic err_kind_e seq_check(input logic [7:0] lead, input logic [7:0] second);
    err_kind_e k;
    k = ERR_NONE;
    priority if (lead == 8'hE0 && second < 8'hA0) begin
      k = ERR_OVERLONG;
    end else if (lead == 8'hED && second >= 8'hA0) begin
      k = ERR_SURROGATE;
    end else if (lead == 8'hF0 && second < 8'h90) begin
      k = ERR_OVERLONG;
    end else if (lead == 8'hF4 && second >= 8'h90) begin
      k = ERR_RANGE;
    end else begin
      k = ERR_NONE;
    end
    return k;
  endfunction

endpackage

>>> rtl/u8vr_in_if.sv
// Input byte channel: valid/ready with byte and end-of-string flag.
interface u8vr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_of_string;

  modport source (output valid, output in_byte, output last_of_string, input ready);
  modport sink   (input valid, input in_byte, input last_of_string, output ready);
endinterface

>>> rtl/u8vr_out_if.sv
// Output word channel: valid/ready with repaired byte and string status.
interface u8vr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_present;
  logic        end_of_string;
  logic        string_valid;
  logic [2:0]  error_kind;
  logic [15:0] error_offset;
  logic [15:0] repl_total;

  modport source (output valid, output out_byte, output byte_present, output end_of_string,
                  output string_valid, output error_kind, output error_offset,
                  output repl_total, input ready);
  modport sink   (input valid, input out_byte, input byte_present, input end_of_string,
                  input string_valid, input error_kind, input error_offset,
                  input repl_total, output ready);
endinterface

>>> rtl/u8vr_front.sv
// Front end: UTF-8 decoder; pushes a packet per byte that yields words or ends a string.
module u8vr_front #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  u8vr_in_if.sink           in_i,
  input  u8vr_pkg::q_stat_t qstat_i,
  output logic              push_o,
  output u8vr_pkg::pkt_t    pkt_o
);
  import u8vr_pkg::*;

  logic                   mode_q;
  logic [7:0]             pend_q [3];
  logic [1:0]             pcnt_q;
  logic [2:0]             elen_q;
  logic [OFFSET_BITS-1:0] pos_q;
  logic [OFFSET_BITS-1:0] seq_q;
  logic                   es_q;
  err_kind_e              ek_q;
  logic [OFFSET_BITS-1:0] eo_q;
  logic [15:0]            repl_q;

  logic [7:0]             s_pend [3];
  logic [1:0]             s_pcnt;
  logic [2:0]             s_elen;
  logic [OFFSET_BITS-1:0] s_seq;
  logic                   s_es;
  err_kind_e              s_ek;
  logic [OFFSET_BITS-1:0] s_eo;
  logic [15:0]            s_repl;
  logic [7:0]             rb [8];
  logic [2:0]             rn;
  lead_class_t            lc;
  err_kind_e              sk;
  logic [7:0]             b;
  logic [7:0]             second;
  logic                   lst;
  logic                   cont;
  logic                   do_lead;
  logic [OFFSET_BITS+15:0] eo_ext;
  logic                   acc;

  assign b         = in_i.in_byte;
  assign lst       = in_i.last_of_string;
  assign in_i.ready = !qstat_i.full;
  assign acc       = in_i.valid && in_i.ready;

  always_comb begin
    s_pend  = pend_q;
    s_pcnt  = pcnt_q;
    s_elen  = elen_q;
    s_seq   = seq_q;
    s_es    = es_q;
    s_ek    = ek_q;
    s_eo    = eo_q;
    s_repl  = repl_q;
    rb      = '{default: 8'h00};
    rn      = 3'd0;
    lc      = lead_class(b);
    cont    = (b[7:6] == 2'b10);
    do_lead = 1'b0;
    second  = (pcnt_q >= 2'd2) ? pend_q[1] : b;
    sk      = seq_check(pend_q[0], second);

    if (elen_q == 3'd0) begin
      do_lead = 1'b1;
    end else if (!cont) begin
      // drop the open bytes, then recheck this byte as a lead
      if (!s_es) begin
        s_es = 1'b1;
        s_ek = ERR_BAD_CONT;
        s_eo = pos_q;
      end
      if (mode_q) begin
        rb[rn] = REPL_B0; rn = rn + 3'd1;
        rb[rn] = REPL_B1; rn = rn + 3'd1;
        rb[rn] = REPL_B2; rn = rn + 3'd1;
      end
      if (s_repl != 16'hFFFF) s_repl = s_repl + 16'd1;
      s_elen  = 3'd0;
      s_pcnt  = 2'd0;
      do_lead = 1'b1;
    end else if (({1'b0, pcnt_q} + 3'd1) < elen_q) begin
      if (pcnt_q == 2'd1) s_pend[1] = b;
      else s_pend[2] = b;
      s_pcnt = pcnt_q + 2'd1;
    end else begin
      if (sk != ERR_NONE) begin
        if (!s_es) begin
          s_es = 1'b1;
          s_ek = sk;
          s_eo = seq_q;
        end
        if (mode_q) begin
          rb[rn] = REPL_B0; rn = rn + 3'd1;
          rb[rn] = REPL_B1; rn = rn + 3'd1;
          rb[rn] = REPL_B2; rn = rn + 3'd1;
        end
        if (s_repl != 16'hFFFF) s_repl = s_repl + 16'd1;
      end else if (mode_q) begin
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < pcnt_q) begin
            rb[rn] = pend_q[i];
            rn     = rn + 3'd1;
          end
        end
        rb[rn] = b;
        rn     = rn + 3'd1;
      end
      s_elen = 3'd0;
      s_pcnt = 2'd0;
    end

    if (do_lead) begin
      if (lc.kind != ERR_NONE) begin
        if (!s_es) begin
          s_es = 1'b1;
          s_ek = lc.kind;
          s_eo = pos_q;
        end
        if (mode_q) begin
          rb[rn] = REPL_B0; rn = rn + 3'd1;
          rb[rn] = REPL_B1; rn = rn + 3'd1;
          rb[rn] = REPL_B2; rn = rn + 3'd1;
        end
        if (s_repl != 16'hFFFF) s_repl = s_repl + 16'd1;
      end else if (lc.len == 3'd0) begin
        if (mode_q) begin
          rb[rn] = b;
          rn     = rn + 3'd1;
        end
      end else begin
        s_elen    = lc.len;
        s_pend[0] = b;
        s_pcnt    = 2'd1;
        s_seq     = pos_q;
      end
    end

    // a sequence still open at the end of the string is truncated
    if (lst && s_elen != 3'd0) begin
      if (!s_es) begin
        s_es = 1'b1;
        s_ek = ERR_TRUNC;
        s_eo = s_seq;
      end
      if (mode_q) begin
        rb[rn] = REPL_B0; rn = rn + 3'd1;
        rb[rn] = REPL_B1; rn = rn + 3'd1;
        rb[rn] = REPL_B2; rn = rn + 3'd1;
      end
      if (s_repl != 16'hFFFF) s_repl = s_repl + 16'd1;
      s_elen = 3'd0;
      s_pcnt = 2'd0;
    end

    eo_ext = {16'h0000, s_eo};

    for (int j = 0; j < MAX_WORDS; j++) begin
      pkt_o.bytes[j] = rb[j];
    end
    pkt_o.nbytes    = rn;
    pkt_o.eos       = lst;
    pkt_o.str_valid = !s_es;
    pkt_o.kind      = s_ek;
    pkt_o.offset    = (eo_ext > (OFFSET_BITS + 16)'(16'hFFFF)) ? 16'hFFFF : eo_ext[15:0];
    pkt_o.repl      = mode_q ? s_repl : 16'h0000;
  end

  assign push_o = acc && (rn != 3'd0 || lst);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      pcnt_q <= 2'd0;
      elen_q <= 3'd0;
      pos_q  <= '0;
      seq_q  <= '0;
      es_q   <= 1'b0;
      ek_q   <= ERR_NONE;
      eo_q   <= '0;
      repl_q <= 16'h0000;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (acc) begin
        if (lst) begin
          pcnt_q <= 2'd0;
          elen_q <= 3'd0;
          pos_q  <= '0;
          seq_q  <= '0;
          es_q   <= 1'b0;
          ek_q   <= ERR_NONE;
          eo_q   <= '0;
          repl_q <= 16'h0000;
        end else begin
          pcnt_q <= s_pcnt;
          elen_q <= s_elen;
          seq_q  <= s_seq;
          es_q   <= s_es;
          ek_q   <= s_ek;
          eo_q   <= s_eo;
          repl_q <= s_repl;
          if (pos_q != {OFFSET_BITS{1'b1}}) pos_q <= pos_q + OFFSET_BITS'(1);
        end
      end
    end
  end

  // pending bytes hold no reset value
  always_ff @(posedge clk_i) begin
    if (acc) pend_q <= s_pend;
  end

endmodule

>>> rtl/u8vr_queue.sv
// Short packet queue between the decoder front end and the output back end.
module u8vr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u8vr_pkg::pkt_t    pkt_i,
  input  logic              pop_i,
  output u8vr_pkg::pkt_t    head_o,
  output u8vr_pkg::q_stat_t stat_o
);
  import u8vr_pkg::*;

  pkt_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q;
  logic [QPTR_W-1:0] rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign head_o       = mem_q[rptr_q];
  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + QPTR_W'(1);
      if (pop_i)  rptr_q <= rptr_q + QPTR_W'(1);
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= pkt_i;
  end

endmodule

>>> rtl/u8vr_back.sv
// Back end: walks each queued packet and sends its words through the output register.
module u8vr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  u8vr_pkg::pkt_t    head_i,
  input  u8vr_pkg::q_stat_t qstat_i,
  output logic              pop_o,
  u8vr_out_if.source        out_o
);
  import u8vr_pkg::*;

  logic        ov_q;
  logic [2:0]  idx_q;
  logic [7:0]  byte_q;
  logic        present_q;
  logic        eos_q;
  logic        valid_q;
  logic [2:0]  kind_q;
  logic [15:0] off_q;
  logic [15:0] repl_q;

  logic [2:0]  last_idx;
  logic        last_ent;
  logic        eos_ent;
  logic        adv;
  logic        load;
  logic [7:0]  byte_sel;

  assign last_idx = (head_i.nbytes == 3'd0) ? 3'd0 : head_i.nbytes - 3'd1;
  assign last_ent = (idx_q == last_idx);
  assign eos_ent  = head_i.eos && last_ent;
  assign adv      = !ov_q || out_o.ready;
  assign load     = adv && !qstat_i.empty;
  assign pop_o    = load && last_ent;

  always_comb begin
    unique case (idx_q)
      3'd0:    byte_sel = head_i.bytes[0];
      3'd1:    byte_sel = head_i.bytes[1];
      3'd2:    byte_sel = head_i.bytes[2];
      3'd3:    byte_sel = head_i.bytes[3];
      3'd4:    byte_sel = head_i.bytes[4];
      3'd5:    byte_sel = head_i.bytes[5];
      default: byte_sel = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      idx_q <= 3'd0;
    end else if (adv) begin
      ov_q <= !qstat_i.empty;
      if (load) idx_q <= last_ent ? 3'd0 : idx_q + 3'd1;
    end
  end

  // status travels only on the string's last word
  always_ff @(posedge clk_i) begin
    if (load) begin
      present_q <= (head_i.nbytes != 3'd0);
      byte_q    <= (head_i.nbytes != 3'd0) ? byte_sel : 8'h00;
      eos_q     <= eos_ent;
      valid_q   <= eos_ent && head_i.str_valid;
      kind_q    <= eos_ent ? head_i.kind : ERR_NONE;
      off_q     <= eos_ent ? head_i.offset : 16'h0000;
      repl_q    <= eos_ent ? head_i.repl : 16'h0000;
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.out_byte      = byte_q;
  assign out_o.byte_present  = present_q;
  assign out_o.end_of_string = eos_q;
  assign out_o.string_valid  = valid_q;
  assign out_o.error_kind    = kind_q;
  assign out_o.error_offset  = off_q;
  assign out_o.repl_total    = repl_q;

endmodule

>>> rtl/utf8_validate_and_repair_core.sv
// UTF-8 validate-and-repair core: streams strings of bytes, gives status or repaired bytes.
//
// in_i takes one byte per word with last_of_string on the final byte of a string.
// out_o gives result words. In strict mode (repair_mode 0) each string yields one
// status word on its last byte. In repair mode valid sequences are passed on when
// they complete and each bad sequence becomes EF BF BD; the string's last word
// carries the status and replacement count.
// cfg_we_i/cfg_wdata_i write repair_mode; write it only while no string is in flight.
// Throughput: one input byte per cycle while the queue has room. Output is one word
// per cycle while out_o.ready is high; a byte may produce up to 6 words, sent in turn.
// The words of a byte pass through the queue and then the output register on their
// way to out_o.
// A 4-packet queue between decoder and output lets the decoder run ahead; in_i.ready
// drops only while that queue is full.
// Reset clears the decoder flags, queue pointers and output valid, and selects strict mode.
// When the receiver stalls, the output word holds, the queue fills, then input stalls.
module utf8_validate_and_repair_core #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  u8vr_in_if.sink     in_i,
  u8vr_out_if.source  out_o
);
  import u8vr_pkg::*;

  pkt_t    pkt_in;
  pkt_t    pkt_head;
  q_stat_t qstat;
  logic    push;
  logic    pop;

  u8vr_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .pkt_o      (pkt_in)
  );

  u8vr_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .pkt_i (pkt_in),
    .pop_i (pop),
    .head_o(pkt_head),
    .stat_o(qstat)
  );

  u8vr_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (pkt_head),
    .qstat_i(qstat),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

>>> rtl/u8vr_checker.sv
// Port-level checks on the result channel, bound to the top level.
`include "utf8_validate_and_repair_core_defines.svh"

module u8vr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_i,
  input logic        byte_present_i,
  input logic        end_of_string_i,
  input logic        string_valid_i,
  input logic [2:0]  error_kind_i,
  input logic [15:0] error_offset_i,
  input logic [15:0] repl_total_i
);

  // hold a stalled word
  `U8VR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_byte_i) && $stable(end_of_string_i))

  // status fields are zero except on the last word of a string
  `U8VR_ASSERT_SAME(a_status_zero, clk_i, rst_ni, out_valid_i && !end_of_string_i, !string_valid_i && error_kind_i == 3'd0 && error_offset_i == 16'h0000 && repl_total_i == 16'h0000)

  // a status-only word closes a string and carries no byte
  `U8VR_ASSERT_SAME(a_status_word, clk_i, rst_ni, out_valid_i && !byte_present_i, end_of_string_i && out_byte_i == 8'h00)

  // a valid string reports no error kind, an invalid one reports some kind
  `U8VR_ASSERT_SAME(a_valid_kind, clk_i, rst_ni, out_valid_i && end_of_string_i, string_valid_i == (error_kind_i == 3'd0))

endmodule

bind utf8_validate_and_repair_core u8vr_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_byte_i     (out_o.out_byte),
  .byte_present_i (out_o.byte_present),
  .end_of_string_i(out_o.end_of_string),
  .string_valid_i (out_o.string_valid),
  .error_kind_i   (out_o.error_kind),
  .error_offset_i (out_o.error_offset),
  .repl_total_i   (out_o.repl_total)
);

>>> sim/tb_utf8_validate_and_repair_core.sv
// Testbench for utf8_validate_and_repair_core: directed and random strings checked word by word.
module tb_utf8_validate_and_repair_core;
  import u8vr_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES  = 80;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int PHASE_BYTES  = 46;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_present;
    logic        end_of_string;
    logic        string_valid;
    logic [2:0]  error_kind;
    logic [15:0] error_offset;
    logic [15:0] repl_total;
  } utf8_word_t;

  class utf8_repair_scoreboard;
    bit          repair_mode;
    logic [7:0]  seq_bytes[3];
    int unsigned seq_count;
    int unsigned seq_len;
    logic [15:0] byte_pos;
    logic [15:0] seq_start;
    logic [15:0] first_off;
    logic [15:0] repl_count;
    bit          err_seen;
    err_kind_e   first_kind;
    utf8_word_t  expected_words[$];
    utf8_word_t  step_words[$];
    int          errors;

    function new();
      repair_mode = 1'b0;
      foreach (seq_bytes[i]) seq_bytes[i] = 8'h00;
      seq_count  = 0;
      seq_len    = 0;
      byte_pos   = '0;
      seq_start  = '0;
      first_off  = '0;
      repl_count = '0;
      err_seen   = 1'b0;
      first_kind = ERR_NONE;
      errors     = 0;
    endfunction

    function void emit(logic [7:0] b, bit present);
      utf8_word_t w;
      if (step_words.size() >= MAX_WORDS) return;
      w = '0;
      w.out_byte     = b;
      w.byte_present = present;
      step_words.insert(step_words.size(), w);
    endfunction

    function void note_error(err_kind_e kind, logic [15:0] at);
      if (!err_seen) begin
        err_seen   = 1'b1;
        first_kind = kind;
        first_off  = at;
      end
    endfunction

    // Put U+FFFD in repair mode; count it in both modes
    function void replace_seq();
      if (repair_mode) begin
        emit(REPL_B0, 1'b1);
        emit(REPL_B1, 1'b1);
        emit(REPL_B2, 1'b1);
      end
      if (repl_count != 16'hFFFF) repl_count++;
    endfunction

    function void open_char(logic [7:0] b, logic [15:0] at);
      if (b <= 8'h7F) begin
        if (repair_mode) emit(b, 1'b1);
      end else if (b[7:6] == 2'b10) begin
        note_error(ERR_UNEXP_CONT, at);
        replace_seq();
      end else if (b == 8'hC0 || b == 8'hC1) begin
        note_error(ERR_OVERLONG, at);
        replace_seq();
      end else if (b >= 8'hF5 && b <= 8'hF7) begin
        note_error(ERR_RANGE, at);
        replace_seq();
      end else if (b >= 8'hF8) begin
        note_error(ERR_BAD_LEAD, at);
        replace_seq();
      end else begin
        seq_len      = (b <= 8'hDF) ? 2 : (b <= 8'hEF) ? 3 : 4;
        seq_bytes[0] = b;
        seq_count    = 1;
        seq_start    = at;
      end
    endfunction

    function void decode_byte(logic [7:0] b, logic last);
      utf8_word_t  w;
      logic [7:0]  second;
      err_kind_e   kind;
      logic [15:0] at;
      at = byte_pos;
      step_words.delete();
      if (seq_len == 0) begin
        open_char(b, at);
      end else if (b[7:6] != 2'b10) begin
        // drop the open bytes, then recheck this one as a lead
        note_error(ERR_BAD_CONT, at);
        replace_seq();
        seq_len   = 0;
        seq_count = 0;
        open_char(b, at);
      end else if (seq_count + 1 < seq_len) begin
        seq_bytes[seq_count] = b;
        seq_count++;
      end else begin
        second = (seq_count >= 2) ? seq_bytes[1] : b;
        kind   = ERR_NONE;
        if (seq_bytes[0] == 8'hE0 && second < 8'hA0) kind = ERR_OVERLONG;
        else if (seq_bytes[0] == 8'hED && second >= 8'hA0) kind = ERR_SURROGATE;
        else if (seq_bytes[0] == 8'hF0 && second < 8'h90) kind = ERR_OVERLONG;
        else if (seq_bytes[0] == 8'hF4 && second >= 8'h90) kind = ERR_RANGE;
        if (kind != ERR_NONE) begin
          note_error(kind, seq_start);
          replace_seq();
        end else if (repair_mode) begin
          for (int i = 0; i < seq_count; i++) emit(seq_bytes[i], 1'b1);
          emit(b, 1'b1);
        end
        seq_len   = 0;
        seq_count = 0;
      end
      if (!last) begin
        if (byte_pos != 16'hFFFF) byte_pos++;
      end else begin
        if (seq_len != 0) begin
          note_error(ERR_TRUNC, seq_start);
          replace_seq();
          seq_len   = 0;
          seq_count = 0;
        end
        if (!repair_mode || step_words.size() == 0) emit(8'h00, 1'b0);
        w = step_words.pop_back();
        w.end_of_string = 1'b1;
        w.string_valid  = !err_seen;
        w.error_kind    = first_kind;
        w.error_offset  = first_off;
        w.repl_total    = repair_mode ? repl_count : 16'h0000;
        step_words.insert(step_words.size(), w);
        byte_pos   = '0;
        seq_start  = '0;
        err_seen   = 1'b0;
        first_kind = ERR_NONE;
        first_off  = '0;
        repl_count = '0;
      end
      foreach (step_words[i]) expected_words.insert(expected_words.size(), step_words[i]);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(utf8_word_t got);
      utf8_word_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected word: out_byte 0x%0h byte_present %0b end_of_string %0b",
               got.out_byte, got.byte_present, got.end_of_string);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("byte_present", want.byte_present, got.byte_present);
      compare_field("end_of_string", want.end_of_string, got.end_of_string);
      compare_field("string_valid", want.string_valid, got.string_valid);
      compare_field("error_kind", want.error_kind, got.error_kind);
      compare_field("error_offset", want.error_offset, got.error_offset);
      compare_field("repl_total", want.repl_total, got.repl_total);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic cfg_wdata;

  u8vr_in_if  byte_bus();
  u8vr_out_if word_bus();

  utf8_repair_scoreboard sb = new();

  int burst_left;
  bit tx_gaps;
  bit hold_off_req;

  utf8_validate_and_repair_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (byte_bus),
    .out_o       (word_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("** utf8_validate_and_repair_core: FAILED **");
    $finish;
  end

  // Check words first, then predict from the byte taken at the same edge
  always @(posedge clk_i) begin
    utf8_word_t got;
    if (rst_ni) begin
      if (word_bus.valid && word_bus.ready) begin
        got.out_byte      = word_bus.out_byte;
        got.byte_present  = word_bus.byte_present;
        got.end_of_string = word_bus.end_of_string;
        got.string_valid  = word_bus.string_valid;
        got.error_kind    = word_bus.error_kind;
        got.error_offset  = word_bus.error_offset;
        got.repl_total    = word_bus.repl_total;
        sb.check_word(got);
      end
      if (byte_bus.valid && byte_bus.ready) begin
        sb.decode_byte(byte_bus.in_byte, byte_bus.last_of_string);
      end
    end
  end

  // Receiver: rotate through stall patterns; hold off on request
  initial begin
    logic [15:0] pat;
    int          k;
    pat = 16'hFFFF;
    k   = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        word_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        if (k % 48 == 0) begin
          case ($urandom_range(0, 3))
            0:       pat = 16'hFFFF;
            1:       pat = 16'($urandom);
            2:       pat = 16'($urandom) | 16'($urandom);
            default: pat = 16'($urandom) & 16'($urandom);
          endcase
        end
        word_bus.ready <= pat[k % 16];
        k++;
      end
    end
  end

  function automatic logic [7:0] rand_cont();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = (tx_gaps && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        byte_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    byte_bus.valid          <= 1'b1;
    byte_bus.in_byte        <= b;
    byte_bus.last_of_string <= last;
    do @(posedge clk_i); while (!byte_bus.ready);
  endtask

  task automatic send_string(input logic [7:0] s[$]);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  // Write the mode only once every word is out and the decoder has caught up
  task automatic set_repair_mode(input logic v);
    byte_bus.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.repair_mode = v;
  endtask

  // Mostly well-formed characters with random content, some broken ones
  task automatic run_phase(input int n_items);
    logic [7:0] s[$];
    logic [7:0] lead;
    int         n;
    int         lead_len;
    n = 0;
    while (n < n_items) begin
      s.delete();
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 99) < 25) begin
          case ($urandom_range(0, 7))
            0: s.insert(s.size(), 8'($urandom_range(0, 255)));
            1: s.insert(s.size(), rand_cont());
            2: begin
              s.insert(s.size(), 8'($urandom_range(8'hC0, 8'hC1)));
              s.insert(s.size(), rand_cont());
            end
            3: s.insert(s.size(), 8'($urandom_range(8'hF5, 8'hFF)));
            4: begin
              // lead with too few continuations
              lead     = 8'($urandom_range(8'hC2, 8'hF4));
              lead_len = (lead <= 8'hDF) ? 2 : (lead <= 8'hEF) ? 3 : 4;
              s.insert(s.size(), lead);
              repeat ($urandom_range(0, lead_len - 2)) s.insert(s.size(), rand_cont());
            end
            5: begin
              s.insert(s.size(), 8'hE0);
              s.insert(s.size(), 8'($urandom_range(8'h80, 8'h9F)));
              s.insert(s.size(), rand_cont());
            end
            6: begin
              s.insert(s.size(), 8'hED);
              s.insert(s.size(), 8'($urandom_range(8'hA0, 8'hBF)));
              s.insert(s.size(), rand_cont());
            end
            default: begin
              if ($urandom_range(0, 1)) begin
                s.insert(s.size(), 8'hF0);
                s.insert(s.size(), 8'($urandom_range(8'h80, 8'h8F)));
              end else begin
                s.insert(s.size(), 8'hF4);
                s.insert(s.size(), 8'($urandom_range(8'h90, 8'hBF)));
              end
              s.insert(s.size(), rand_cont());
              s.insert(s.size(), rand_cont());
            end
          endcase
        end else begin
          case ($urandom_range(0, 3))
            0: s.insert(s.size(), 8'($urandom_range(0, 8'h7F)));
            1: begin
              s.insert(s.size(), 8'($urandom_range(8'hC2, 8'hDF)));
              s.insert(s.size(), rand_cont());
            end
            2: begin
              lead = 8'($urandom_range(8'hE0, 8'hEF));
              s.insert(s.size(), lead);
              if (lead == 8'hE0) s.insert(s.size(), 8'($urandom_range(8'hA0, 8'hBF)));
              else if (lead == 8'hED) s.insert(s.size(), 8'($urandom_range(8'h80, 8'h9F)));
              else s.insert(s.size(), rand_cont());
              s.insert(s.size(), rand_cont());
            end
            default: begin
              lead = 8'($urandom_range(8'hF0, 8'hF4));
              s.insert(s.size(), lead);
              if (lead == 8'hF0) s.insert(s.size(), 8'($urandom_range(8'h90, 8'hBF)));
              else if (lead == 8'hF4) s.insert(s.size(), 8'($urandom_range(8'h80, 8'h8F)));
              else s.insert(s.size(), rand_cont());
              s.insert(s.size(), rand_cont());
              s.insert(s.size(), rand_cont());
            end
          endcase
        end
      end
      send_string(s);
      n += s.size();
    end
  endtask

  initial begin
    rst_ni                  <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_wdata               <= 1'b0;
    byte_bus.valid          <= 1'b0;
    byte_bus.in_byte        <= 8'h00;
    byte_bus.last_of_string <= 1'b0;
    word_bus.ready          <= 1'b0;
    burst_left   = 0;
    tx_gaps      = 1'b1;
    hold_off_req = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: lead errors, bad continuation, truncation, whole-sequence errors
    set_repair_mode(1'b1);
    send_string('{8'h7F, 8'hE0, 8'hA0, 8'h80, 8'h80, 8'hC0, 8'hF5, 8'hFF,
                  8'hC2, 8'h41, 8'hE1, 8'h80});
    send_string('{8'hF0, 8'h8F, 8'hBF, 8'hBF, 8'hF4, 8'h90, 8'h80, 8'h80});
    send_string('{8'h00});
    set_repair_mode(1'b0);
    send_string('{8'hED, 8'hA0, 8'h80});
    send_string('{8'hC2, 8'h80});

    // Mode change mid-string
    tx_gaps = 1'b0;
    for (int i = 0; i < 3; i++) send_byte(8'hFF, 1'b0);
    set_repair_mode(1'b1);
    send_byte(8'h41, 1'b1);
    set_repair_mode(1'b0);
    for (int i = 0; i < 3; i++) send_byte(8'h61, 1'b0);
    send_byte(8'h80, 1'b1);
    tx_gaps = 1'b1;

    set_repair_mode(1'b1);
    run_phase(PHASE_BYTES);
    set_repair_mode(1'b0);
    run_phase(PHASE_BYTES);
    // Back-to-back input while the receiver holds off: fill the block
    set_repair_mode(1'b1);
    tx_gaps      = 1'b0;
    hold_off_req = 1'b1;
    run_phase(PHASE_BYTES);
    tx_gaps = 1'b1;
    set_repair_mode(1'b0);
    run_phase(PHASE_BYTES);
    set_repair_mode(1'b1);
    run_phase(PHASE_BYTES);

    byte_bus.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("** utf8_validate_and_repair_core: PASSED **");
    end else begin
      $display("** utf8_validate_and_repair_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/u8vr_pkg.sv
rtl/u8vr_in_if.sv
rtl/u8vr_out_if.sv
rtl/u8vr_front.sv
rtl/u8vr_queue.sv
rtl/u8vr_back.sv
rtl/utf8_validate_and_repair_core.sv
rtl/u8vr_checker.sv
sim/tb_utf8_validate_and_repair_core.sv
